/* rtl/core/bbs_pkg.sv */
// ----------------------------------------------------------------------------
// bbs_pkg
// Shared constants of the bidirectional bubble sorter: data width and default
// store depth.
// ----------------------------------------------------------------------------
package bbs_pkg;

   localparam int BBS_DATA_W = 32;
   localparam int BBS_DEPTH  = 64;

endpackage

/* rtl/core/bbs_ram.sv */
// ----------------------------------------------------------------------------
// bbs_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port. A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module bbs_ram
   import bbs_pkg::*;
#(
   parameter int WIDTH = BBS_DATA_W,
   parameter int DEPTH = BBS_DEPTH
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/core/bidirectional_bubble_sorter.sv */
// ----------------------------------------------------------------------------
// bidirectional_bubble_sorter
// Collects a set of signed values, sorts them in a RAM by cocktail shaker
// passes and streams them out smallest first.
// ----------------------------------------------------------------------------
// Input items are taken one per cycle while the block is collecting; items
// beyond DEPTH are dropped and flagged as overflow on every result of the run.
// The item with req_last high closes the set and starts sorting, during which
// no input is accepted. Sorting runs in the single value RAM: each forward or
// backward pass over a window reads one entry per compare step through the
// registered RAM read port, after a fill read and before a final write-back,
// the window shrinks by one after each pass, and sorting ends after the first
// pass without a swap. Results then leave one at a time, each read from the
// RAM and held until rsp_ready takes it, and the next set is accepted once
// the last result is taken.
// ----------------------------------------------------------------------------
module bidirectional_bubble_sorter
   import bbs_pkg::*;
#(
   parameter int DEPTH = BBS_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [BBS_DATA_W-1:0] req_value,
   input  logic                         req_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [BBS_DATA_W-1:0] rsp_value_res,
   output logic                         rsp_last_res,
   output logic                         rsp_overflow
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [10:0] {
      S_IDLE     = 11'b000_0000_0001,
      S_FWD_A    = 11'b000_0000_0010,
      S_FWD_B    = 11'b000_0000_0100,
      S_FWD_C    = 11'b000_0000_1000,
      S_FWD_D    = 11'b000_0001_0000,
      S_BWD_A    = 11'b000_0010_0000,
      S_BWD_B    = 11'b000_0100_0000,
      S_BWD_C    = 11'b000_1000_0000,
      S_BWD_D    = 11'b001_0000_0000,
      S_OUT_LD   = 11'b010_0000_0000,
      S_OUT_HOLD = 11'b100_0000_0000
   } state_type;

   state_type             state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic                  dropped_ff, dropped_in;
   logic [AW-1:0]         lo_ff, lo_in;
   logic [AW-1:0]         hi_ff, hi_in;
   logic [AW-1:0]         idx_ff, idx_in;
   logic [AW-1:0]         k_ff, k_in;
   logic                  swapped_ff, swapped_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BBS_DATA_W-1:0] carry_ff, carry_in;
   logic [BBS_DATA_W-1:0] rsp_value_ff;
   logic                  rsp_last_ff;
   logic                  rsp_overflow_ff;
   logic                  rsp_load;

   logic                  ram_we;
   logic [AW-1:0]         ram_waddr;
   logic [BBS_DATA_W-1:0] ram_wdata;
   logic [AW-1:0]         ram_raddr;
   logic [BBS_DATA_W-1:0] ram_rdata;

   bbs_ram #(
      .WIDTH (BBS_DATA_W),
      .DEPTH (DEPTH)
   ) u_value_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      idx_in       = idx_ff;
      k_in         = k_ff;
      swapped_in   = swapped_ff;
      rsp_valid_in = rsp_valid_ff;
      carry_in     = carry_ff;
      rsp_load     = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = idx_ff;
      ram_wdata    = carry_ff;
      ram_raddr    = lo_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (count_ff < CW'(DEPTH)) begin
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[AW-1:0];
                  ram_wdata = req_value;
                  count_in  = count_ff + CW'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last) begin
                  lo_in    = '0;
                  hi_in    = AW'(count_in - CW'(1));
                  state_in = S_FWD_A;
               end
            end
         end
         S_FWD_A: begin
            swapped_in = 1'b0;
            if (lo_ff >= hi_ff) begin
               k_in     = '0;
               ram_raddr = '0;
               state_in = S_OUT_LD;
            end else begin
               ram_raddr = lo_ff;
               idx_in    = lo_ff + AW'(1);
               state_in  = S_FWD_B;
            end
         end
         S_FWD_B: begin
            carry_in  = ram_rdata;
            ram_raddr = idx_ff;
            state_in  = S_FWD_C;
         end
         S_FWD_C: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff - AW'(1);
            if ($signed(carry_ff) > $signed(ram_rdata)) begin
               ram_wdata  = ram_rdata;
               swapped_in = 1'b1;
            end else begin
               ram_wdata = carry_ff;
               carry_in  = ram_rdata;
            end
            if (idx_ff == hi_ff) begin
               state_in = S_FWD_D;
            end else begin
               ram_raddr = idx_ff + AW'(1);
               idx_in    = idx_ff + AW'(1);
            end
         end
         S_FWD_D: begin
            ram_we    = 1'b1;
            ram_waddr = hi_ff;
            ram_wdata = carry_ff;
            if (!swapped_ff) begin
               k_in      = '0;
               ram_raddr = '0;
               state_in  = S_OUT_LD;
            end else begin
               hi_in    = hi_ff - AW'(1);
               state_in = S_BWD_A;
            end
         end
         S_BWD_A: begin
            swapped_in = 1'b0;
            if (hi_ff <= lo_ff) begin
               k_in      = '0;
               ram_raddr = '0;
               state_in  = S_OUT_LD;
            end else begin
               ram_raddr = hi_ff;
               idx_in    = hi_ff - AW'(1);
               state_in  = S_BWD_B;
            end
         end
         S_BWD_B: begin
            carry_in  = ram_rdata;
            ram_raddr = idx_ff;
            state_in  = S_BWD_C;
         end
         S_BWD_C: begin
            ram_we    = 1'b1;
            ram_waddr = idx_ff + AW'(1);
            if ($signed(ram_rdata) > $signed(carry_ff)) begin
               ram_wdata  = ram_rdata;
               swapped_in = 1'b1;
            end else begin
               ram_wdata = carry_ff;
               carry_in  = ram_rdata;
            end
            if (idx_ff == lo_ff) begin
               state_in = S_BWD_D;
            end else begin
               ram_raddr = idx_ff - AW'(1);
               idx_in    = idx_ff - AW'(1);
            end
         end
         S_BWD_D: begin
            ram_we    = 1'b1;
            ram_waddr = lo_ff;
            ram_wdata = carry_ff;
            lo_in     = lo_ff + AW'(1);
            if (!swapped_ff) begin
               k_in      = '0;
               ram_raddr = '0;
               state_in  = S_OUT_LD;
            end else begin
               state_in = S_FWD_A;
            end
         end
         S_OUT_LD: begin
            rsp_load     = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = S_OUT_HOLD;
         end
         S_OUT_HOLD: begin
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_IDLE;
               end else begin
                  k_in      = k_ff + AW'(1);
                  ram_raddr = k_ff + AW'(1);
                  state_in  = S_OUT_LD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         lo_ff        <= '0;
         hi_ff        <= '0;
         idx_ff       <= '0;
         k_ff         <= '0;
         swapped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         lo_ff        <= lo_in;
         hi_ff        <= hi_in;
         idx_ff       <= idx_in;
         k_ff         <= k_in;
         swapped_ff   <= swapped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
      if (rsp_load) begin
         rsp_value_ff    <= ram_rdata;
         rsp_last_ff     <= (CW'(k_ff) == count_ff - CW'(1));
         rsp_overflow_ff <= dropped_ff;
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_res = rsp_value_ff;
   assign rsp_last_res  = rsp_last_ff;
   assign rsp_overflow  = rsp_overflow_ff;

   // The collector never takes an item while a result is pending.
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while a result is pending");

   // The store count never exceeds the depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("item count beyond store depth");

   // A closing item always starts a forward pass.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last) |=> (state_ff == S_FWD_A))
      else $error("final item did not start sorting");

   // The sort window never inverts while a pass is being set up.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FWD_A || state_ff == S_BWD_D) |-> (lo_ff <= hi_ff))
      else $error("sort window inverted");

endmodule

/* tb/sv/bbs_checker.sv */
// ----------------------------------------------------------------------------
// bbs_checker
// Watches both channels of the bidirectional bubble sorter, keeps its own
// copy of the collected set, sorts it by shaker passes when the closing item
// is taken and compares every result taken from the block, in order, with
// the predicted sorted run.
// ----------------------------------------------------------------------------
module bbs_checker
   import bbs_pkg::*;
#(
   parameter int DEPTH = BBS_DEPTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [BBS_DATA_W-1:0] req_value,
   input  logic                         req_last,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic signed [BBS_DATA_W-1:0] rsp_value_res,
   input  logic                         rsp_last_res,
   input  logic                         rsp_overflow,
   output int                           error_count,
   output int                           pending_count,
   output int                           result_count
);

   typedef struct packed {
      logic [BBS_DATA_W-1:0] value;
      logic                  last;
      logic                  overflow;
   } sorted_entry_type;

   sorted_entry_type             sorted_q[$];
   logic signed [BBS_DATA_W-1:0] held [DEPTH];
   int                          held_n;
   logic                        held_drop;

   initial begin
      error_count   = 0;
      pending_count = 0;
      result_count  = 0;
      held_n        = 0;
      held_drop     = 1'b0;
   end

   task automatic report_error(input string msg);
      if (error_count < 40) begin
         $display("ERROR: result %0d: %s", result_count, msg);
      end
      error_count++;
   endtask

   function automatic void shake_held(input int n);
      int                          lo;
      int                          hi;
      int                          i;
      bit                          swapped;
      logic signed [BBS_DATA_W-1:0] t;
      lo      = 0;
      hi      = (n > 0) ? n - 1 : 0;
      swapped = 1'b1;
      while (swapped) begin
         swapped = 1'b0;
         for (i = lo; i < hi; i++) begin
            if (held[i] > held[i+1]) begin
               t         = held[i];
               held[i]   = held[i+1];
               held[i+1] = t;
               swapped   = 1'b1;
            end
         end
         if (!swapped) break;
         swapped = 1'b0;
         if (hi > 0) hi--;
         for (i = hi; i > lo; i--) begin
            if (held[i-1] > held[i]) begin
               t         = held[i-1];
               held[i-1] = held[i];
               held[i]   = t;
               swapped   = 1'b1;
            end
         end
         lo++;
      end
   endfunction

   always @(posedge clock) begin
      sorted_entry_type want;
      int               k;
      if (reset) begin
         sorted_q.delete();
         held_n    = 0;
         held_drop = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sorted_q.size() == 0) begin
               report_error($sformatf("value %0d arrived with nothing expected",
                                      rsp_value_res));
            end else begin
               want = sorted_q.pop_front();
               if (rsp_value_res !== want.value)
                  report_error($sformatf("value expected %0d got %0d",
                                         $signed(want.value), rsp_value_res));
               if (rsp_last_res !== want.last)
                  report_error($sformatf("last expected %0b got %0b",
                                         want.last, rsp_last_res));
               if (rsp_overflow !== want.overflow)
                  report_error($sformatf("overflow expected %0b got %0b",
                                         want.overflow, rsp_overflow));
            end
            result_count++;
         end
         if (req_valid && req_ready) begin
            if (held_n < DEPTH) begin
               held[held_n] = req_value;
               held_n++;
            end else begin
               held_drop = 1'b1;
            end
            if (req_last) begin
               shake_held(held_n);
               for (k = 0; k < held_n; k++) begin
                  want.value    = held[k];
                  want.last     = (k == held_n - 1);
                  want.overflow = held_drop;
                  sorted_q.push_back(want);
               end
               held_n    = 0;
               held_drop = 1'b0;
            end
         end
      end
      pending_count = sorted_q.size();
   end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench top of the bidirectional bubble sorter. Sends directed sets
// (single value, extremes, equal values, reversed and presorted runs) and
// then random sets of mostly small sizes with some full and overflowing
// ones, under four idling phases (none, input only, output only, both). A checker beside the
// block predicts and compares every sorted result.
// ----------------------------------------------------------------------------
module tb;
   import bbs_pkg::*;

   localparam int RANDOM_ITEMS = 280;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 200;

   localparam logic signed [BBS_DATA_W-1:0] VMAX = 32'sh7fffffff;
   localparam logic signed [BBS_DATA_W-1:0] VMIN = 32'sh80000000;

   logic                         clock     = 1'b0;
   logic                         reset     = 1'b1;
   logic                         req_valid = 1'b0;
   logic signed [BBS_DATA_W-1:0] req_value = '0;
   logic                         req_last  = 1'b0;
   logic                         rsp_ready = 1'b0;
   logic                         req_ready;
   logic                         rsp_valid;
   logic signed [BBS_DATA_W-1:0] rsp_value_res;
   logic                         rsp_last_res;
   logic                         rsp_overflow;

   int fail_count;
   int pending_count;
   int result_count;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int cycle_count  = 0;
   int items_sent   = 0;
   int sets_sent    = 0;
   int over_sets    = 0;

   logic signed [BBS_DATA_W-1:0] extremes [7] = '{VMAX, VMIN, 0, -1, 1, VMIN, VMAX};

   bidirectional_bubble_sorter u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_overflow  (rsp_overflow)
   );

   bbs_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_value_res (rsp_value_res),
      .rsp_last_res  (rsp_last_res),
      .rsp_overflow  (rsp_overflow),
      .error_count   (fail_count),
      .pending_count (pending_count),
      .result_count  (result_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99, 0) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding",
                  cycle_count, pending_count);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_item(input logic signed [BBS_DATA_W-1:0] v, input logic fin);
      while ($urandom_range(99, 0) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= fin;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
      if (fin) sets_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   function automatic logic signed [BBS_DATA_W-1:0] pick_value();
      int r;
      r = $urandom_range(9, 0);
      if (r < 6) return $urandom;
      if (r < 8) return $signed($urandom_range(8, 0)) - 4;
      case ($urandom_range(3, 0))
         0:       return VMAX;
         1:       return VMIN;
         2:       return 0;
         default: return -1;
      endcase
   endfunction

   function automatic int pick_size();
      int r;
      r = $urandom_range(99, 0);
      if (r < 75) return $urandom_range(8, 1);
      if (r < 90) return $urandom_range(40, 9);
      if (r < 95) return BBS_DEPTH;
      return $urandom_range(BBS_DEPTH + 6, BBS_DEPTH + 1);
   endfunction

   task automatic send_random_set(input int n);
      int k;
      if (n > BBS_DEPTH) over_sets++;
      for (k = 0; k < n; k++) begin
         send_item(pick_value(), k == n - 1);
      end
   endtask

   initial begin
      int ph;
      int i;
      int phase_start;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_item(32'sd5, 1'b1);
      for (i = 0; i < 7; i++) send_item(extremes[i], i == 6);
      for (i = 0; i < 4; i++) send_item(32'sd3, i == 3);
      for (i = 8; i >= 1; i--) send_item(i, i == 1);
      for (i = -2; i <= 1; i++) send_item(i, i == 1);

      for (ph = 0; ph < 4; ph++) begin
         wait_drained();
         idle_pct    = (ph == 1) ? 73 : (ph == 3) ? 27 : 0;
         stall_pct   = (ph == 2) ? 73 : (ph == 3) ? 27 : 0;
         phase_start = items_sent;
         if (ph == 0) send_random_set(BBS_DEPTH);
         if (ph == 2) send_random_set(BBS_DEPTH + 3);
         if (ph == 3) send_random_set(BBS_DEPTH + 1);
         while (items_sent - phase_start < RANDOM_ITEMS / 4) begin
            if ($urandom_range(7, 0) == 0) wait_drained();
            send_random_set(pick_size());
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items in %0d sets, %0d sets beyond the store depth.",
               items_sent, sets_sent, over_sets);
      $display("Checked %0d sorted results over four idling phases.", result_count);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

/* bidirectional_bubble_sorter.f */
rtl/core/bbs_pkg.sv
rtl/core/bbs_ram.sv
rtl/core/bidirectional_bubble_sorter.sv
tb/sv/bbs_checker.sv
tb/sv/tb.sv
